>>> sv/tmak_pkg.sv
package tmak_pkg;

   localparam int ACC_WIDTH = 10;
   localparam int THR_W = 8;
   localparam int DELTA_W = 8;
   localparam int TAP_CAP = 32;
   localparam int TAP_CNT_W = $clog2(TAP_CAP) + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W = 2;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(8);
   localparam logic [THR_W-1:0] THRESHOLD_MIN = THR_W'(4);

   localparam logic OP_MOTION = 1'b0;
   localparam logic OP_KEY = 1'b1;

   localparam logic [1:0] KEY_CLICK = 2'd0;
   localparam logic [1:0] KEY_BACK = 2'd1;
   localparam logic [1:0] KEY_SHIFT = 2'd2;

   localparam logic [1:0] KEY_PRESSED = 2'd0;
   localparam logic [1:0] KEY_RELEASED = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_MODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVATION = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_HOLD = 2'd3;

   typedef enum logic [1:0] {
      KIND_TAP    = 2'd0,
      KIND_BUTTON = 2'd1,
      KIND_MOTION = 2'd2,
      KIND_STATUS = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      TAP_LEFT  = 3'd0,
      TAP_RIGHT = 3'd1,
      TAP_UP    = 3'd2,
      TAP_DOWN  = 3'd3,
      TAP_ENTER = 3'd4
   } tap_type;

   typedef enum logic [1:0] {
      JOB_KEYS  = 2'd0,
      JOB_MOUSE = 2'd1,
      JOB_KEY   = 2'd2
   } job_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ADD,
      BK_HTAP,
      BK_VTAP,
      BK_MOUSE,
      BK_ACTION,
      BK_STATUS
   } back_state_type;

   typedef struct packed {
      job_kind_type       job_kind;
      logic [DELTA_W-1:0] dx;
      logic [DELTA_W-1:0] dy;
      logic               act_valid;
      logic               act_button;
      logic               button_down;
      logic               consumed;
      logic               shift_reset;
      logic               touch_on;
      logic               indicator_on;
   } job_type;

   typedef struct packed {
      kind_type           kind;
      tap_type            tap_key;
      logic               button_down;
      logic [DELTA_W-1:0] rel_x;
      logic [DELTA_W-1:0] rel_y;
      logic               consumed;
      logic               touch_on;
      logic               shift_reset;
      logic               indicator_on;
      logic               last;
   } result_type;

   typedef logic signed [ACC_WIDTH:0] accw_type;
   typedef logic signed [ACC_WIDTH-1:0] acc_type;

   localparam accw_type ACC_MAX_W = accw_type'(2 ** (ACC_WIDTH - 1) - 1);
   localparam accw_type ACC_MIN_W = accw_type'(-(2 ** (ACC_WIDTH - 1)));

   function automatic accw_type thr_wide(logic [THR_W-1:0] t);
      return accw_type'({{(ACC_WIDTH + 1 - THR_W){1'b0}}, t});
   endfunction

   function automatic logic tap_neg(acc_type acc, logic [THR_W-1:0] t);
      accw_type s;
      s = accw_type'(acc) + thr_wide(t);
      return s[ACC_WIDTH] || (s == '0);
   endfunction

   function automatic logic tap_pos(acc_type acc, logic [THR_W-1:0] t);
      return accw_type'(acc) > thr_wide(t);
   endfunction

   function automatic acc_type tap_step(acc_type acc, logic [THR_W-1:0] t);
      accw_type s;
      if (tap_neg(acc, t)) begin
         s = accw_type'(acc) + thr_wide(t);
      end else begin
         s = accw_type'(acc) - thr_wide(t);
      end
      return acc_type'(s[ACC_WIDTH-1:0]);
   endfunction

   function automatic acc_type sat_add(acc_type acc, logic signed [DELTA_W-1:0] d);
      accw_type s;
      s = accw_type'(acc) + accw_type'(d);
      if (s > ACC_MAX_W) begin
         s = ACC_MAX_W;
      end else if (s < ACC_MIN_W) begin
         s = ACC_MIN_W;
      end
      return acc_type'(s[ACC_WIDTH-1:0]);
   endfunction

   function automatic acc_type snap_idle(acc_type acc, logic [DELTA_W-1:0] d,
                                         logic [THR_W-1:0] t);
      accw_type a;
      a = accw_type'(acc);
      if (d == '0 && a < thr_wide(t) && a > -thr_wide(t)) begin
         return '0;
      end
      return acc;
   endfunction

endpackage

>>> sv/tmak_queue.sv
module tmak_queue
   import tmak_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type wr_job,
   output logic    full,
   input  logic    pop,
   output job_type rd_job,
   output logic    empty
);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign rd_job = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

>>> sv/tmak_front.sv
module tmak_front
   import tmak_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_opcode,
   input  logic signed [DELTA_W-1:0] req_delta_x,
   input  logic signed [DELTA_W-1:0] req_delta_y,
   input  logic [1:0]                req_key_class,
   input  logic [1:0]                req_key_state,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [THR_W-1:0]          csr_data,
   output logic                      q_push,
   output job_type                   q_job,
   input  logic                      q_full,
   output logic [THR_W-1:0]          threshold
);

   logic [THR_W-1:0] threshold_ff, threshold_in;
   logic             mode_ff, mode_in;
   logic             activation_ff, activation_in;
   logic             shift_hold_ff, shift_hold_in;
   logic             touch_ff, touch_in;
   logic             eds_ff, eds_in;
   logic             ind_ff, ind_in;
   logic             accept, pressed, released;
   job_type          job;

   assign req_full = q_full;
   assign csr_ready = 1'b1;
   assign accept = req_push && !q_full;
   assign threshold = threshold_ff;
   assign pressed = (req_key_state == KEY_PRESSED);
   assign released = (req_key_state == KEY_RELEASED);
   assign q_job = job;

   always_comb begin
      threshold_in = threshold_ff;
      mode_in = mode_ff;
      activation_in = activation_ff;
      shift_hold_in = shift_hold_ff;
      touch_in = touch_ff;
      eds_in = eds_ff;
      ind_in = ind_ff;
      job = '0;
      job.dx = req_delta_x;
      job.dy = req_delta_y;
      q_push = 1'b0;

      if (accept) begin
         if (req_opcode == OP_MOTION) begin
            if (touch_ff && (req_delta_x != '0 || req_delta_y != '0)) begin
               eds_in = 1'b1;
               q_push = 1'b1;
               job.job_kind = mode_ff ? JOB_MOUSE : JOB_KEYS;
            end
         end else begin
            q_push = 1'b1;
            job.job_kind = JOB_KEY;
            case (req_key_class)
               KEY_CLICK: begin
                  if (touch_ff) begin
                     if (!mode_ff && released) begin
                        job.act_valid = 1'b1;
                     end else if (mode_ff) begin
                        job.act_valid = 1'b1;
                        job.act_button = 1'b1;
                        job.button_down = pressed;
                     end
                     job.consumed = 1'b1;
                  end else if (released) begin
                     touch_in = 1'b1;
                     if (!mode_ff) begin
                        ind_in = 1'b1;
                     end
                  end
               end
               KEY_BACK: begin
                  if (touch_ff) begin
                     if (released) begin
                        touch_in = 1'b0;
                        ind_in = 1'b0;
                     end
                     job.consumed = 1'b1;
                  end
               end
               KEY_SHIFT: begin
                  if (!activation_ff && shift_hold_ff) begin
                     if (!touch_ff && pressed) begin
                        eds_in = 1'b0;
                        touch_in = 1'b1;
                     end else if (touch_ff && released) begin
                        touch_in = 1'b0;
                        ind_in = 1'b0;
                        if (eds_ff) begin
                           eds_in = 1'b0;
                           job.shift_reset = 1'b1;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
      job.touch_on = touch_in;
      job.indicator_on = ind_in;

      if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD: begin
               threshold_in = (csr_data < THRESHOLD_MIN) ? THRESHOLD_MIN : csr_data;
            end
            CSR_OUTPUT_MODE: begin
               mode_in = csr_data[0];
            end
            CSR_ACTIVATION: begin
               activation_in = csr_data[0];
               touch_in = csr_data[0];
               if (!csr_data[0]) begin
                  ind_in = 1'b0;
               end
            end
            CSR_SHIFT_HOLD: begin
               shift_hold_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         mode_ff <= 1'b0;
         activation_ff <= 1'b0;
         shift_hold_ff <= 1'b1;
         touch_ff <= 1'b0;
         eds_ff <= 1'b0;
         ind_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         mode_ff <= mode_in;
         activation_ff <= activation_in;
         shift_hold_ff <= shift_hold_in;
         touch_ff <= touch_in;
         eds_ff <= eds_in;
         ind_ff <= ind_in;
      end
   end

endmodule

>>> sv/tmak_back.sv
module tmak_back
   import tmak_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [THR_W-1:0] threshold,
   input  job_type          q_job,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_valid,
   output result_type       rsp,
   input  logic             rsp_pop
);

   back_state_type         state_ff, state_in;
   job_type                job_ff, job_in;
   acc_type                acc_h_ff, acc_h_in;
   acc_type                acc_v_ff, acc_v_in;
   logic [TAP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;
   result_type             res;
   logic                   can_emit;
   logic                   h_neg, h_pos, v_neg, v_pos;
   acc_type                h_next, v_next;
   logic                   h_more, v_more;

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign can_emit = !rsp_valid_ff || rsp_pop;

   assign h_neg = tap_neg(acc_h_ff, threshold);
   assign h_pos = tap_pos(acc_h_ff, threshold);
   assign v_neg = tap_neg(acc_v_ff, threshold);
   assign v_pos = tap_pos(acc_v_ff, threshold);
   assign h_next = tap_step(acc_h_ff, threshold);
   assign v_next = tap_step(acc_v_ff, threshold);
   assign h_more = (cnt_ff != TAP_CNT_W'(TAP_CAP - 1))
                   && (tap_neg(h_next, threshold) || tap_pos(h_next, threshold));
   assign v_more = (cnt_ff != TAP_CNT_W'(TAP_CAP - 1))
                   && (tap_neg(v_next, threshold) || tap_pos(v_next, threshold));

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      acc_h_in = acc_h_ff;
      acc_v_in = acc_v_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      res = '0;
      res.touch_on = job_ff.touch_on;
      res.indicator_on = job_ff.indicator_on;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               job_in = q_job;
               case (q_job.job_kind)
                  JOB_KEYS:  state_in = BK_ADD;
                  JOB_MOUSE: state_in = BK_MOUSE;
                  JOB_KEY:   state_in = q_job.act_valid ? BK_ACTION : BK_STATUS;
                  default:   state_in = BK_IDLE;
               endcase
            end
         end
         BK_ADD: begin
            acc_h_in = snap_idle(sat_add(acc_h_ff, job_ff.dx), job_ff.dx, threshold);
            acc_v_in = snap_idle(sat_add(acc_v_ff, job_ff.dy), job_ff.dy, threshold);
            cnt_in = '0;
            state_in = BK_HTAP;
         end
         BK_HTAP: begin
            if (cnt_ff == TAP_CNT_W'(TAP_CAP) || !(h_neg || h_pos)) begin
               cnt_in = '0;
               state_in = BK_VTAP;
            end else if (can_emit) begin
               res.kind = KIND_TAP;
               res.tap_key = h_neg ? TAP_LEFT : TAP_RIGHT;
               res.last = !h_more && !(v_neg || v_pos);
               rsp_valid_in = 1'b1;
               rsp_in = res;
               acc_h_in = h_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         BK_VTAP: begin
            if (cnt_ff == TAP_CNT_W'(TAP_CAP) || !(v_neg || v_pos)) begin
               state_in = BK_IDLE;
            end else if (can_emit) begin
               res.kind = KIND_TAP;
               res.tap_key = v_neg ? TAP_UP : TAP_DOWN;
               res.last = !v_more;
               rsp_valid_in = 1'b1;
               rsp_in = res;
               acc_v_in = v_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         BK_MOUSE: begin
            if (can_emit) begin
               res.kind = KIND_MOTION;
               res.rel_x = job_ff.dx;
               res.rel_y = job_ff.dy;
               res.last = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = res;
               state_in = BK_IDLE;
            end
         end
         BK_ACTION: begin
            if (can_emit) begin
               if (job_ff.act_button) begin
                  res.kind = KIND_BUTTON;
                  res.button_down = job_ff.button_down;
               end else begin
                  res.kind = KIND_TAP;
                  res.tap_key = TAP_ENTER;
               end
               rsp_valid_in = 1'b1;
               rsp_in = res;
               state_in = BK_STATUS;
            end
         end
         BK_STATUS: begin
            if (can_emit) begin
               res.kind = KIND_STATUS;
               res.consumed = job_ff.consumed;
               res.shift_reset = job_ff.shift_reset;
               res.last = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = res;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         acc_h_ff <= '0;
         acc_v_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_h_ff <= acc_h_in;
         acc_v_ff <= acc_v_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

endmodule

>>> sv/touch_motion_to_arrow_keys.sv
// An accepted word is queued, popped by the back end and its results registered; keys mode
// first adds the deltas to the accumulators. A keys-mode report gives up to 64 arrow taps,
// one per cycle from the tap sequencer while the receiver takes each result.
// The front takes a new word while the 2-entry job queue has room.
// Synchronous active-high reset clears the touch state, the accumulators and the
// queues and loads the register defaults; no clearing pass is needed.
module touch_motion_to_arrow_keys
   import tmak_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_opcode,
   input  logic signed [DELTA_W-1:0] req_delta_x,
   input  logic signed [DELTA_W-1:0] req_delta_y,
   input  logic [1:0]                req_key_class,
   input  logic [1:0]                req_key_state,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [1:0]                rsp_kind,
   output logic [2:0]                rsp_tap_key,
   output logic                      rsp_button_down,
   output logic signed [DELTA_W-1:0] rsp_rel_x,
   output logic signed [DELTA_W-1:0] rsp_rel_y,
   output logic                      rsp_consumed,
   output logic                      rsp_touch_on,
   output logic                      rsp_shift_reset,
   output logic                      rsp_indicator_on,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [THR_W-1:0]          csr_data
);

   logic             q_push, q_full, q_pop, q_empty;
   job_type          wr_job, rd_job;
   logic [THR_W-1:0] threshold;
   logic             rsp_valid;
   result_type       rsp;

   tmak_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_opcode    (req_opcode),
      .req_delta_x   (req_delta_x),
      .req_delta_y   (req_delta_y),
      .req_key_class (req_key_class),
      .req_key_state (req_key_state),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_push        (q_push),
      .q_job         (wr_job),
      .q_full        (q_full),
      .threshold     (threshold)
   );

   tmak_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_job (wr_job),
      .full   (q_full),
      .pop    (q_pop),
      .rd_job (rd_job),
      .empty  (q_empty)
   );

   tmak_back u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold),
      .q_job     (rd_job),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_empty = !rsp_valid;
   assign rsp_kind = rsp.kind;
   assign rsp_tap_key = rsp.tap_key;
   assign rsp_button_down = rsp.button_down;
   assign rsp_rel_x = rsp.rel_x;
   assign rsp_rel_y = rsp.rel_y;
   assign rsp_consumed = rsp.consumed;
   assign rsp_touch_on = rsp.touch_on;
   assign rsp_shift_reset = rsp.shift_reset;
   assign rsp_indicator_on = rsp.indicator_on;
   assign rsp_last = rsp.last;

endmodule

>>> sim/tb_touch_motion_to_arrow_keys.sv
module tb_touch_motion_to_arrow_keys
   import tmak_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam bit OUT_KEYS = 1'b0;
   localparam bit OUT_MOUSE = 1'b1;
   localparam bit ACT_CLICK = 1'b0;
   localparam bit ACT_ALWAYS = 1'b1;
   localparam logic [1:0] KEY_OTHER = 2'd3;
   localparam logic [1:0] KEY_HOLD = 2'd2;
   localparam logic [1:0] KEY_UNKNOWN = 2'd3;
   localparam int FROM_MODEL = -1;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 47;
   localparam int ACC_HI = 2 ** (ACC_WIDTH - 1) - 1;
   localparam int ACC_LO = -(2 ** (ACC_WIDTH - 1));

   typedef struct packed {
      bit                       is_csr;
      logic [CSR_INDEX_W-1:0]   idx;
      logic [THR_W-1:0]         val;
      logic                     op;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [1:0]               cls;
      logic [1:0]               st;
      int                       n_typed;
      result_type               res;
   } drow_type;

   logic                      clock;
   logic                      reset;
   logic                      req_push;
   logic                      req_full;
   logic                      req_opcode;
   logic signed [DELTA_W-1:0] req_delta_x;
   logic signed [DELTA_W-1:0] req_delta_y;
   logic [1:0]                req_key_class;
   logic [1:0]                req_key_state;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic [1:0]                rsp_kind;
   logic [2:0]                rsp_tap_key;
   logic                      rsp_button_down;
   logic signed [DELTA_W-1:0] rsp_rel_x;
   logic signed [DELTA_W-1:0] rsp_rel_y;
   logic                      rsp_consumed;
   logic                      rsp_touch_on;
   logic                      rsp_shift_reset;
   logic                      rsp_indicator_on;
   logic                      rsp_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [THR_W-1:0]          csr_data;

   // predicted touch state and registers
   logic [THR_W-1:0] thr_cfg;
   bit               mode_cfg;
   bit               act_cfg;
   bit               shift_hold_cfg;
   int               acc_h;
   int               acc_v;
   bit               touch_st;
   bit               entry_shift_st;
   bit               indicator_st;

   result_type expected_words[$];
   result_type step_words[$];
   drow_type   directed_rows[$];
   int         mismatch_count;
   int         word_count;
   int         burst_left;
   bit         gaps_on;
   bit         hold_req;
   bit         hold_done;

   touch_motion_to_arrow_keys i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_opcode(req_opcode),
      .req_delta_x(req_delta_x),
      .req_delta_y(req_delta_y),
      .req_key_class(req_key_class),
      .req_key_state(req_key_state),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_tap_key(rsp_tap_key),
      .rsp_button_down(rsp_button_down),
      .rsp_rel_x(rsp_rel_x),
      .rsp_rel_y(rsp_rel_y),
      .rsp_consumed(rsp_consumed),
      .rsp_touch_on(rsp_touch_on),
      .rsp_shift_reset(rsp_shift_reset),
      .rsp_indicator_on(rsp_indicator_on),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   function automatic int acc_clip(int v);
      if (v > ACC_HI) begin
         return ACC_HI;
      end
      if (v < ACC_LO) begin
         return ACC_LO;
      end
      return v;
   endfunction

   task automatic emit_taps(inout int acc, input int t, input tap_type neg_key,
                            input tap_type pos_key);
      result_type r;
      int c;
      c = 0;
      r = '0;
      r.kind = KIND_TAP;
      if (acc <= -t) begin
         r.tap_key = neg_key;
         while (acc <= -t && c < TAP_CAP) begin
            step_words.push_back(r);
            acc += t;
            c++;
         end
      end else if (acc > t) begin
         r.tap_key = pos_key;
         while (acc > t && c < TAP_CAP) begin
            step_words.push_back(r);
            acc -= t;
            c++;
         end
      end
   endtask

   task automatic predict_word(input logic op, input logic signed [DELTA_W-1:0] dx,
                               input logic signed [DELTA_W-1:0] dy,
                               input logic [1:0] cls, input logic [1:0] st);
      result_type r;
      int t;
      bit pressed;
      bit released;
      bit cons;
      bit sreset;
      step_words.delete();
      t = int'(thr_cfg);
      r = '0;
      if (op == OP_MOTION) begin
         if (!touch_st || (dx == 0 && dy == 0)) begin
            return;
         end
         entry_shift_st = 1'b1;
         if (mode_cfg == OUT_MOUSE) begin
            r.kind = KIND_MOTION;
            r.rel_x = dx;
            r.rel_y = dy;
            step_words.push_back(r);
         end else begin
            acc_h = acc_clip(acc_h + int'(dx));
            acc_v = acc_clip(acc_v + int'(dy));
            if (dx == 0 && acc_h < t && acc_h > -t) begin
               acc_h = 0;
            end
            if (dy == 0 && acc_v < t && acc_v > -t) begin
               acc_v = 0;
            end
            emit_taps(acc_h, t, TAP_LEFT, TAP_RIGHT);
            emit_taps(acc_v, t, TAP_UP, TAP_DOWN);
         end
      end else begin
         pressed = (st == KEY_PRESSED);
         released = (st == KEY_RELEASED);
         cons = 1'b0;
         sreset = 1'b0;
         if (cls == KEY_CLICK) begin
            if (touch_st) begin
               if (mode_cfg == OUT_KEYS && released) begin
                  r.kind = KIND_TAP;
                  r.tap_key = TAP_ENTER;
                  step_words.push_back(r);
               end else if (mode_cfg == OUT_MOUSE) begin
                  r.kind = KIND_BUTTON;
                  r.button_down = pressed;
                  step_words.push_back(r);
               end
               cons = 1'b1;
            end else if (released) begin
               touch_st = 1'b1;
               if (mode_cfg == OUT_KEYS) begin
                  indicator_st = 1'b1;
               end
            end
         end else if (cls == KEY_BACK && touch_st) begin
            if (released) begin
               touch_st = 1'b0;
               indicator_st = 1'b0;
            end
            cons = 1'b1;
         end else if (cls == KEY_SHIFT) begin
            if (act_cfg == ACT_CLICK && shift_hold_cfg) begin
               if (!touch_st && pressed) begin
                  entry_shift_st = 1'b0;
                  touch_st = 1'b1;
               end else if (touch_st && released) begin
                  touch_st = 1'b0;
                  indicator_st = 1'b0;
                  if (entry_shift_st) begin
                     entry_shift_st = 1'b0;
                     sreset = 1'b1;
                  end
               end
            end
         end
         r = '0;
         r.kind = KIND_STATUS;
         r.consumed = cons;
         r.shift_reset = sreset;
         step_words.push_back(r);
      end
      foreach (step_words[k]) begin
         step_words[k].touch_on = touch_st;
         step_words[k].indicator_on = indicator_st;
         step_words[k].last = (k == step_words.size() - 1);
      end
   endtask

   function automatic result_type status_word(bit cons, bit sreset, bit on, bit ind);
      result_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.consumed = cons;
      r.shift_reset = sreset;
      r.touch_on = on;
      r.indicator_on = ind;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void word_row(logic op, logic signed [DELTA_W-1:0] dx,
                                    logic signed [DELTA_W-1:0] dy, logic [1:0] cls,
                                    logic [1:0] st, int n_typed, result_type res);
      drow_type d;
      d = '0;
      d.op = op;
      d.dx = dx;
      d.dy = dy;
      d.cls = cls;
      d.st = st;
      d.n_typed = n_typed;
      d.res = res;
      directed_rows.push_back(d);
   endfunction

   function automatic void csr_row(logic [CSR_INDEX_W-1:0] idx, logic [THR_W-1:0] val);
      drow_type d;
      d = '0;
      d.is_csr = 1'b1;
      d.idx = idx;
      d.val = val;
      directed_rows.push_back(d);
   endfunction

   function automatic string fmt_word(result_type w);
      return {$sformatf("kind %0d tap %0d btn %0d rel %0d,%0d cons %0d ", w.kind, w.tap_key,
                        w.button_down, $signed(w.rel_x), $signed(w.rel_y), w.consumed),
              $sformatf("on %0d sreset %0d ind %0d last %0d", w.touch_on, w.shift_reset,
                        w.indicator_on, w.last)};
   endfunction

   task automatic push_word(input logic op, input logic signed [DELTA_W-1:0] dx,
                            input logic signed [DELTA_W-1:0] dy, input logic [1:0] cls,
                            input logic [1:0] st, input int n_typed, input result_type res);
      int gap;
      if (burst_left == 0) begin
         if (gaps_on && !(hold_req && !hold_done)) begin
            gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 70 : 6);
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_push <= 1'b1;
      req_opcode <= op;
      req_delta_x <= dx;
      req_delta_y <= dy;
      req_key_class <= cls;
      req_key_state <= st;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_word(op, dx, dy, cls, st);
      if (n_typed == FROM_MODEL) begin
         foreach (step_words[k]) expected_words.push_back(step_words[k]);
      end else if (n_typed == 1) begin
         expected_words.push_back(res);
      end
   endtask

   // drain every expected word, then give a silent keys-mode report time to finish
   task automatic settle();
      req_push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [THR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_THRESHOLD: thr_cfg = (val < THRESHOLD_MIN) ? THRESHOLD_MIN : val;
         CSR_OUTPUT_MODE: mode_cfg = val[0];
         CSR_ACTIVATION: begin
            act_cfg = val[0];
            if (act_cfg == ACT_ALWAYS) begin
               touch_st = 1'b1;
            end else begin
               touch_st = 1'b0;
               indicator_st = 1'b0;
            end
         end
         CSR_SHIFT_HOLD: shift_hold_cfg = val[0];
         default: begin
         end
      endcase
   endtask

   function automatic logic signed [DELTA_W-1:0] rand_delta();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return DELTA_W'($urandom_range(0, 40) - 20);
         default: return DELTA_W'($urandom);
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      int len;
      rsp_pop = 1'b0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(1, 60);
            repeat (len) begin
               case (mode)
                  0: rsp_pop <= 1'b1;
                  1: rsp_pop <= 1'($urandom);
                  default: rsp_pop <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      result_type got;
      result_type want;
      bit bad;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '0;
         got.kind = kind_type'(rsp_kind);
         got.tap_key = tap_type'(rsp_tap_key);
         got.button_down = rsp_button_down;
         got.rel_x = rsp_rel_x;
         got.rel_y = rsp_rel_y;
         got.consumed = rsp_consumed;
         got.touch_on = rsp_touch_on;
         got.shift_reset = rsp_shift_reset;
         got.indicator_on = rsp_indicator_on;
         got.last = rsp_last;
         word_count++;
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("rsp word %0d unexpected: %s", word_count, fmt_word(got));
            end
         end else begin
            want = expected_words.pop_front();
            bad = (got.kind !== want.kind) || (got.tap_key !== want.tap_key) ||
                  (got.button_down !== want.button_down) || (got.rel_x !== want.rel_x) ||
                  (got.rel_y !== want.rel_y) || (got.consumed !== want.consumed) ||
                  (got.touch_on !== want.touch_on) || (got.shift_reset !== want.shift_reset) ||
                  (got.indicator_on !== want.indicator_on) || (got.last !== want.last);
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("rsp word %0d expected: %s", word_count, fmt_word(want));
                  $display("rsp word %0d actual:   %s", word_count, fmt_word(got));
               end
            end
         end
      end
   end

   initial begin
      result_type none;
      logic op;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [1:0] cls;
      logic [1:0] st;
      logic [THR_W-1:0] val;
      int acted;

      none = '0;
      reset = 1'b1;
      req_push = 1'b0;
      req_opcode = OP_MOTION;
      req_delta_x = '0;
      req_delta_y = '0;
      req_key_class = KEY_CLICK;
      req_key_state = KEY_PRESSED;
      csr_valid = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_data = '0;
      thr_cfg = THRESHOLD_RESET;
      mode_cfg = OUT_KEYS;
      act_cfg = ACT_CLICK;
      shift_hold_cfg = 1'b1;
      acc_h = 0;
      acc_v = 0;
      touch_st = 1'b0;
      entry_shift_st = 1'b0;
      indicator_st = 1'b0;
      mismatch_count = 0;
      word_count = 0;
      burst_left = 0;
      gaps_on = 1'b1;
      hold_req = 1'b0;

      word_row(OP_MOTION, 8'sd127, -8'sd128, KEY_CLICK, KEY_PRESSED, 0, none);
      word_row(OP_KEY, 0, 0, KEY_BACK, KEY_PRESSED, 1, status_word(0, 0, 0, 0));
      word_row(OP_KEY, 0, 0, KEY_OTHER, KEY_UNKNOWN, 1, status_word(0, 0, 0, 0));
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_PRESSED, 1, status_word(0, 0, 0, 0));
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_RELEASED, 1, status_word(0, 0, 1, 1));
      word_row(OP_MOTION, 0, 0, KEY_CLICK, KEY_PRESSED, 0, none);
      word_row(OP_MOTION, 8'sd127, 0, KEY_OTHER, KEY_HOLD, FROM_MODEL, none);
      word_row(OP_MOTION, -8'sd128, -8'sd128, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_MOTION, 0, 8'sd5, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_MOTION, 8'sd1, 0, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_RELEASED, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_HOLD, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_BACK, KEY_UNKNOWN, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_BACK, KEY_RELEASED, 1, status_word(1, 0, 0, 0));
      word_row(OP_KEY, 0, 0, KEY_SHIFT, KEY_PRESSED, 1, status_word(0, 0, 1, 0));
      word_row(OP_MOTION, 8'sd3, 0, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_SHIFT, KEY_RELEASED, 1, status_word(0, 1, 0, 0));
      word_row(OP_KEY, 0, 0, KEY_SHIFT, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_SHIFT, KEY_RELEASED, 1, status_word(0, 0, 0, 0));
      csr_row(CSR_THRESHOLD, 8'd0);
      csr_row(CSR_SHIFT_HOLD, 8'hFE);
      word_row(OP_KEY, 0, 0, KEY_SHIFT, KEY_PRESSED, 1, status_word(0, 0, 0, 0));
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_RELEASED, FROM_MODEL, none);
      word_row(OP_MOTION, 8'sd127, 8'sd127, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_MOTION, 8'sd127, 8'sd127, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_MOTION, -8'sd128, -8'sd128, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      csr_row(CSR_THRESHOLD, 8'd255);
      word_row(OP_MOTION, 8'sd127, -8'sd1, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_MOTION, 8'sd127, 8'sd127, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      csr_row(CSR_OUTPUT_MODE, 8'hFF);
      word_row(OP_MOTION, -8'sd128, 8'sd127, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_PRESSED, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_RELEASED, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_UNKNOWN, FROM_MODEL, none);
      csr_row(CSR_ACTIVATION, 8'hFE);
      word_row(OP_MOTION, 8'sd5, 8'sd5, KEY_CLICK, KEY_PRESSED, 0, none);
      word_row(OP_KEY, 0, 0, KEY_CLICK, KEY_RELEASED, 1, status_word(0, 0, 1, 0));
      csr_row(CSR_ACTIVATION, 8'h01);
      word_row(OP_KEY, 0, 0, KEY_SHIFT, KEY_RELEASED, FROM_MODEL, none);
      word_row(OP_KEY, 0, 0, KEY_BACK, KEY_RELEASED, FROM_MODEL, none);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            settle();
            write_csr(directed_rows[i].idx, directed_rows[i].val);
            csr_valid <= 1'b0;
         end else begin
            push_word(directed_rows[i].op, directed_rows[i].dx, directed_rows[i].dy,
                      directed_rows[i].cls, directed_rows[i].st,
                      directed_rows[i].n_typed, directed_rows[i].res);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph == 0) begin
            val = THR_W'($urandom_range(0, 3));
         end else if (ph == 1) begin
            val = 8'd255;
         end else if ($urandom_range(0, 3) == 0) begin
            val = THR_W'($urandom);
         end else begin
            val = THR_W'($urandom_range(4, 24));
         end
         write_csr(CSR_THRESHOLD, val);
         val = THR_W'($urandom);
         val[0] = (ph == 4) || ($urandom_range(0, 9) < 3);
         write_csr(CSR_OUTPUT_MODE, val);
         val = THR_W'($urandom);
         val[0] = (ph == 5) || ($urandom_range(0, 3) == 0);
         write_csr(CSR_ACTIVATION, val);
         val = THR_W'($urandom);
         val[0] = (ph != 6) && ($urandom_range(0, 3) != 0);
         write_csr(CSR_SHIFT_HOLD, val);
         csr_valid <= 1'b0;
         if (ph == 3) begin
            hold_req = 1'b1;
         end
         gaps_on = (ph % 3 != 1);
         acted = 0;
         while (acted < WORDS_PER_PHASE) begin
            dx = rand_delta();
            dy = rand_delta();
            cls = 2'($urandom);
            st = 2'($urandom);
            if (!touch_st && $urandom_range(0, 2) != 0) begin
               op = OP_KEY;
               if ($urandom_range(0, 1) == 0) begin
                  cls = KEY_CLICK;
                  st = KEY_RELEASED;
               end else begin
                  cls = KEY_SHIFT;
                  st = KEY_PRESSED;
               end
            end else begin
               op = ($urandom_range(0, 9) < 7) ? OP_MOTION : OP_KEY;
            end
            if (!(op == OP_MOTION && (!touch_st || (dx == 0 && dy == 0)))) begin
               acted++;
            end
            push_word(op, dx, dy, cls, st, FROM_MODEL, none);
         end
      end

      req_push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> touch_motion_to_arrow_keys.f
sv/tmak_pkg.sv
sv/tmak_queue.sv
sv/tmak_front.sv
sv/tmak_back.sv
sv/touch_motion_to_arrow_keys.sv
sim/tb_touch_motion_to_arrow_keys.sv
